// ----- hw/rtl/tlik_pkg.sv -----
// Shared widths, constants and the arctangent table for the leg IK pipeline.
package tlik_pkg;

    localparam int SEG_W       = 15;
    localparam int COORD_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN    = 24;
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int VEC_W       = 48;
    localparam int MAG_W       = 42;
    localparam int Z_W         = 32;
    localparam int NORM_TOP    = 40;   // normalized magnitude lands in [2^40, 2^41)
    localparam int NORM_STAGES = 6;
    localparam int LANES       = 3;    // knee acos, hip acos, hip atan
    localparam int LANE_KNEE   = 0;
    localparam int LANE_HIP    = 1;
    localparam int LANE_PHI    = 2;

    localparam logic [SEG_W-1:0] UPPER_RST = 15'd2458;
    localparam logic [SEG_W-1:0] LOWER_RST = 15'd3277;

    // angles in 2^-16 degree
    localparam logic signed [Z_W-1:0] DEG_90  = 32'sd5898240;
    localparam logic signed [Z_W-1:0] DEG_180 = 32'sd11796480;
    localparam logic signed [Z_W-1:0] ROUND_HALF = 32'sd512;
    localparam int ROUND_SHIFT = 10;
    localparam logic signed [Z_W-1:0] OUT_LIMIT = 32'sd23040;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPPER = 1'b0,
        REG_LOWER = 1'b1
    } cfg_idx_t;

    // state carried alongside the square-root cells
    typedef struct packed {
        logic                     bad;
        logic                     xneg;
        logic signed [32:0]       ck;
        logic signed [32:0]       ch;
        logic signed [COORD_W:0]  xp;
        logic signed [COORD_W:0]  yp;
    } side_a_t;

    // special-case flags carried alongside the normalize and CORDIC cells
    typedef struct packed {
        logic bad;
        logic xneg;
        logic k_szero;
        logic k_cneg;
        logic k_czero;
        logic h_szero;
        logic h_cneg;
        logic h_czero;
        logic p_xzero;
        logic p_yzero;
        logic p_ypos;
    } side_b_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [Z_W-1:0] atan_lut(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 32'sd2949120;
            1:  v = 32'sd1740967;
            2:  v = 32'sd919879;
            3:  v = 32'sd466945;
            4:  v = 32'sd234379;
            5:  v = 32'sd117304;
            6:  v = 32'sd58666;
            7:  v = 32'sd29335;
            8:  v = 32'sd14668;
            9:  v = 32'sd7334;
            10: v = 32'sd3667;
            11: v = 32'sd1833;
            12: v = 32'sd917;
            13: v = 32'sd458;
            14: v = 32'sd229;
            15: v = 32'sd115;
            16: v = 32'sd57;
            17: v = 32'sd29;
            18: v = 32'sd14;
            19: v = 32'sd7;
            20: v = 32'sd4;
            21: v = 32'sd2;
            22: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [VEC_W-1:0] v);
        logic signed [VEC_W-1:0] a;
        a = v[VEC_W-1] ? -v : v;
        return MAG_W'(a);
    endfunction

endpackage

// ----- hw/rtl/tlik_sqrt_cell.sv -----
// One result bit of a pipelined restoring integer square root.
module tlik_sqrt_cell
    import tlik_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    output logic [RAD_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out
);

    localparam logic [RAD_W-1:0]  ONE_SQ  = RAD_W'(1) << (2 * BIT);
    localparam logic [ROOT_W-1:0] ONE_BIT = ROOT_W'(1) << BIT;

    logic [RAD_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RAD_W-1:0]  trial;

    // (root + 2^i)^2 - root^2
    assign trial = (RAD_W'(root_in) << (BIT + 1)) + ONE_SQ;

    always_comb begin
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            root_next = root_in | ONE_BIT;
        end else begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ----- hw/rtl/tlik_norm_cell.sv -----
// One binary step of the vector normalizing shift ahead of the CORDIC.
module tlik_norm_cell
    import tlik_pkg::*;
#(
    parameter int SHIFT = 1
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [VEC_W-1:0] x_in,
    input  logic signed [VEC_W-1:0] y_in,
    input  logic [MAG_W-1:0]        m_in,
    output logic signed [VEC_W-1:0] x_out,
    output logic signed [VEC_W-1:0] y_out,
    output logic [MAG_W-1:0]        m_out
);

    localparam logic [MAG_W-1:0] LIMIT = MAG_W'(1) << (NORM_TOP + 1 - SHIFT);

    logic signed [VEC_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [MAG_W-1:0]        m_reg, m_next;

    always_comb begin
        if (m_in < LIMIT) begin
            x_next = x_in <<< SHIFT;
            y_next = y_in <<< SHIFT;
            m_next = m_in << SHIFT;
        end else begin
            x_next = x_in;
            y_next = y_in;
            m_next = m_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            m_reg <= m_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign m_out = m_reg;

endmodule

// ----- hw/rtl/tlik_cordic_cell.sv -----
// One vectoring-mode CORDIC iteration with its angle accumulator.
module tlik_cordic_cell
    import tlik_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [VEC_W-1:0] x_in,
    input  logic signed [VEC_W-1:0] y_in,
    input  logic signed [Z_W-1:0]   z_in,
    output logic signed [VEC_W-1:0] x_out,
    output logic signed [VEC_W-1:0] y_out,
    output logic signed [Z_W-1:0]   z_out
);

    localparam logic signed [Z_W-1:0] ATAN = atan_lut(IDX);

    logic signed [VEC_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic signed [VEC_W-1:0] xs, ys;

    assign xs = x_in >>> IDX;
    assign ys = y_in >>> IDX;

    always_comb begin
        if (y_in[VEC_W-1]) begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- hw/rtl/two_link_leg_inverse_kinematics_top.sv -----
// Throughput: one request per cycle while the output is not stalled. Every stage is a
// register, among them the 32 root cells in two lanes, and the 6 normalize cells and
// CORDIC_STAGES rotation cells in three parallel lanes.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (aresetn, synchronous, active low) empties the pipeline and loads the segment
// lengths 2458 and 4 * 819.25 (3277) in Q1.14; data registers are not reset.
module two_link_leg_inverse_kinematics_top
    import tlik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [SEG_W-1:0]          cfg_wdata,
    // foot target request
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_foot_x,
    input  logic signed [COORD_W-1:0] s_foot_y,
    // joint angle result
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ANGLE_W-1:0] m_hip_angle,
    output logic signed [ANGLE_W-1:0] m_knee_angle,
    output logic                      m_unreachable
);

    localparam int PIPE_N = 4 + ROOT_W + NORM_STAGES + CORDIC_STAGES + 2;
    localparam int SIDE_B_N = NORM_STAGES + CORDIC_STAGES;

    // ---------------- configuration ----------------
    logic [SEG_W-1:0] upper_len_reg, lower_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_len_reg <= UPPER_RST;
            lower_len_reg <= LOWER_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                REG_UPPER: upper_len_reg <= cfg_wdata;
                REG_LOWER: lower_len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Single advance enable: every stage moves when the output slot frees up.
    logic              adv;
    logic [PIPE_N-1:0] vld_reg, vld_next;

    assign adv     = !vld_reg[PIPE_N-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[PIPE_N-1];
    assign vld_next = {vld_reg[PIPE_N-2:0], s_valid && s_ready};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 1: squares and products ----------------
    logic signed [COORD_W-1:0] x1_reg, y1_reg;
    logic [30:0]               xx1_reg, yy1_reg;
    logic [29:0]               a2_1_reg, b2_1_reg, ab1_reg;
    logic signed [31:0]        xx_s, yy_s;
    logic [29:0]               a2_w, b2_w, ab_w;

    assign xx_s = s_foot_x * s_foot_x;
    assign yy_s = s_foot_y * s_foot_y;
    assign a2_w = upper_len_reg * upper_len_reg;
    assign b2_w = lower_len_reg * lower_len_reg;
    assign ab_w = upper_len_reg * lower_len_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg   <= s_foot_x;
            y1_reg   <= s_foot_y;
            xx1_reg  <= 31'(xx_s);
            yy1_reg  <= 31'(yy_s);
            a2_1_reg <= a2_w;
            b2_1_reg <= b2_w;
            ab1_reg  <= ab_w;
        end
    end

    // ---------------- stage 2: law-of-cosines numerators ----------------
    logic signed [COORD_W-1:0] x2_reg, y2_reg;
    logic [31:0]               d2_2_reg;
    logic [30:0]               tab2_reg;
    logic signed [32:0]        ck2_reg, ch2_reg;
    logic [29:0]               a2_2_reg;
    logic [31:0]               d2_w;

    assign d2_w = 32'(xx1_reg) + 32'(yy1_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            d2_2_reg <= d2_w;
            tab2_reg <= {ab1_reg, 1'b0};
            ck2_reg  <= 33'(a2_1_reg) + 33'(b2_1_reg) - 33'(d2_w);
            ch2_reg  <= 33'(d2_w) + 33'(a2_1_reg) - 33'(b2_1_reg);
            a2_2_reg <= a2_1_reg;
        end
    end

    // ---------------- stage 3: squared radii and numerators ----------------
    logic signed [COORD_W-1:0] x3_reg, y3_reg;
    logic signed [32:0]        ck3_reg, ch3_reg;
    logic [RAD_W-1:0]          ck_sq3_reg, rk_sq3_reg, ch_sq3_reg, rh_sq3_reg;
    logic                      bad3_reg;
    logic [31:0]               ck_abs, ch_abs;
    logic [RAD_W-1:0]          ck_sq_w, ch_sq_w, rk_sq_w;
    logic [61:0]               ad_w;

    assign ck_abs  = ck2_reg[32] ? 32'(-ck2_reg) : 32'(ck2_reg);
    assign ch_abs  = ch2_reg[32] ? 32'(-ch2_reg) : 32'(ch2_reg);
    assign ck_sq_w = ck_abs * ck_abs;
    assign ch_sq_w = ch_abs * ch_abs;
    assign rk_sq_w = tab2_reg * tab2_reg;
    assign ad_w    = a2_2_reg * d2_2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;
            ck3_reg    <= ck2_reg;
            ch3_reg    <= ch2_reg;
            ck_sq3_reg <= ck_sq_w;
            ch_sq3_reg <= ch_sq_w;
            rk_sq3_reg <= rk_sq_w;
            rh_sq3_reg <= {ad_w, 2'b00};
            bad3_reg   <= (d2_2_reg == '0);
        end
    end

    // ---------------- stage 4: sine-part radicands ----------------
    logic [RAD_W-1:0] radk4_reg, radh4_reg;
    side_a_t          side4_reg, side4_next;
    logic             k_out, h_out;

    assign k_out = rk_sq3_reg < ck_sq3_reg;
    assign h_out = rh_sq3_reg < ch_sq3_reg;

    always_comb begin
        side4_next.bad  = bad3_reg || k_out || h_out;
        side4_next.xneg = x3_reg[COORD_W-1];
        side4_next.ck   = ck3_reg;
        side4_next.ch   = ch3_reg;
        side4_next.xp   = x3_reg[COORD_W-1] ? -(COORD_W+1)'(x3_reg) : (COORD_W+1)'(x3_reg);
        side4_next.yp   = x3_reg[COORD_W-1] ? -(COORD_W+1)'(y3_reg) : (COORD_W+1)'(y3_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            radk4_reg <= k_out ? '0 : rk_sq3_reg - ck_sq3_reg;
            radh4_reg <= h_out ? '0 : rh_sq3_reg - ch_sq3_reg;
            side4_reg <= side4_next;
        end
    end

    // ---------------- square-root cells, knee and hip ----------------
    logic [RAD_W-1:0]  sq_rem  [2][ROOT_W+1];
    logic [ROOT_W-1:0] sq_root [2][ROOT_W+1];
    side_a_t           side_a_reg [ROOT_W];

    assign sq_rem[0][0]  = radk4_reg;
    assign sq_rem[1][0]  = radh4_reg;
    assign sq_root[0][0] = '0;
    assign sq_root[1][0] = '0;

    for (genvar l = 0; l < 2; l++) begin : g_sq
        for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
            tlik_sqrt_cell #(
                .BIT(ROOT_W - 1 - k)
            ) u_cell (
                .aclk    (aclk),
                .en      (adv),
                .rem_in  (sq_rem[l][k]),
                .root_in (sq_root[l][k]),
                .rem_out (sq_rem[l][k+1]),
                .root_out(sq_root[l][k+1])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_a_reg[0] <= side4_reg;
            for (int k = 1; k < ROOT_W; k++) begin
                side_a_reg[k] <= side_a_reg[k-1];
            end
        end
    end

    // ---------------- lane setup: (s, -c) for each acos, folded (x, y) for atan ----------------
    side_a_t                 sa;
    side_b_t                 side_b_in;
    logic signed [VEC_W-1:0] nx [LANES][NORM_STAGES+1];
    logic signed [VEC_W-1:0] ny [LANES][NORM_STAGES+1];
    logic [MAG_W-1:0]        nm [LANES][NORM_STAGES+1];

    assign sa = side_a_reg[ROOT_W-1];

    assign nx[LANE_KNEE][0] = VEC_W'(sq_root[0][ROOT_W]);
    assign ny[LANE_KNEE][0] = -VEC_W'(sa.ck);
    assign nx[LANE_HIP][0]  = VEC_W'(sq_root[1][ROOT_W]);
    assign ny[LANE_HIP][0]  = -VEC_W'(sa.ch);
    assign nx[LANE_PHI][0]  = VEC_W'(sa.xp);
    assign ny[LANE_PHI][0]  = VEC_W'(sa.yp);

    for (genvar l = 0; l < LANES; l++) begin : g_mag
        assign nm[l][0] = (mag_of(nx[l][0]) > mag_of(ny[l][0])) ? mag_of(nx[l][0])
                                                                 : mag_of(ny[l][0]);
    end

    always_comb begin
        side_b_in.bad     = sa.bad;
        side_b_in.xneg    = sa.xneg;
        side_b_in.k_szero = (sq_root[0][ROOT_W] == '0);
        side_b_in.k_cneg  = sa.ck[32];
        side_b_in.k_czero = (sa.ck == '0);
        side_b_in.h_szero = (sq_root[1][ROOT_W] == '0);
        side_b_in.h_cneg  = sa.ch[32];
        side_b_in.h_czero = (sa.ch == '0);
        side_b_in.p_xzero = (sa.xp == '0);
        side_b_in.p_yzero = (sa.yp == '0);
        side_b_in.p_ypos  = !sa.yp[COORD_W] && (sa.yp != '0);
    end

    // ---------------- normalize and CORDIC cells ----------------
    logic signed [VEC_W-1:0] cx [LANES][CORDIC_STAGES+1];
    logic signed [VEC_W-1:0] cy [LANES][CORDIC_STAGES+1];
    logic signed [Z_W-1:0]   cz [LANES][CORDIC_STAGES+1];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
            tlik_norm_cell #(
                .SHIFT((1 << (NORM_STAGES - 1)) >> j)
            ) u_norm (
                .aclk (aclk),
                .en   (adv),
                .x_in (nx[l][j]),
                .y_in (ny[l][j]),
                .m_in (nm[l][j]),
                .x_out(nx[l][j+1]),
                .y_out(ny[l][j+1]),
                .m_out(nm[l][j+1])
            );
        end

        assign cx[l][0] = nx[l][NORM_STAGES];
        assign cy[l][0] = ny[l][NORM_STAGES];
        assign cz[l][0] = '0;

        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
            tlik_cordic_cell #(
                .IDX(i)
            ) u_rot (
                .aclk (aclk),
                .en   (adv),
                .x_in (cx[l][i]),
                .y_in (cy[l][i]),
                .z_in (cz[l][i]),
                .x_out(cx[l][i+1]),
                .y_out(cy[l][i+1]),
                .z_out(cz[l][i+1])
            );
        end
    end

    side_b_t side_b_reg [SIDE_B_N];

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_b_reg[0] <= side_b_in;
            for (int k = 1; k < SIDE_B_N; k++) begin
                side_b_reg[k] <= side_b_reg[k-1];
            end
        end
    end

    // ---------------- combine: special cases, joint sums ----------------
    side_b_t               sb;
    logic signed [Z_W-1:0] knee_acos, hip_acos, phi;
    logic signed [Z_W-1:0] hip_sum_reg, hip_sum_next, knee_sum_reg, knee_sum_next;
    logic                  bad_reg;

    assign sb = side_b_reg[SIDE_B_N-1];

    always_comb begin
        // acos with zero sine part clamps to 0 or 180 by the sign of the numerator
        if (sb.k_szero) begin
            knee_acos = sb.k_cneg ? DEG_180 : '0;
        end else begin
            knee_acos = DEG_90 + (sb.k_czero ? '0 : cz[LANE_KNEE][CORDIC_STAGES]);
        end
        if (sb.h_szero) begin
            hip_acos = sb.h_cneg ? DEG_180 : '0;
        end else begin
            hip_acos = DEG_90 + (sb.h_czero ? '0 : cz[LANE_HIP][CORDIC_STAGES]);
        end
        if (sb.p_yzero) begin
            phi = '0;
        end else if (sb.p_xzero) begin
            phi = sb.p_ypos ? DEG_90 : -DEG_90;
        end else begin
            phi = cz[LANE_PHI][CORDIC_STAGES];
        end
        knee_sum_next = DEG_180 - knee_acos;
        hip_sum_next  = phi - hip_acos - DEG_90 + (sb.xneg ? DEG_180 : '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hip_sum_reg  <= hip_sum_next;
            knee_sum_reg <= knee_sum_next;
            bad_reg      <= sb.bad;
        end
    end

    // ---------------- output: round to 1/64 degree and saturate ----------------
    function automatic logic signed [ANGLE_W-1:0] to_out(input logic signed [Z_W-1:0] v);
        logic signed [Z_W-1:0] q;
        q = (v + ROUND_HALF) >>> ROUND_SHIFT;
        if (q > OUT_LIMIT) begin
            q = OUT_LIMIT;
        end else if (q < -OUT_LIMIT) begin
            q = -OUT_LIMIT;
        end
        return ANGLE_W'(q);
    endfunction

    logic signed [ANGLE_W-1:0] hip_out_reg, knee_out_reg;
    logic                      unr_out_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            hip_out_reg  <= to_out(hip_sum_reg);
            knee_out_reg <= to_out(knee_sum_reg);
            unr_out_reg  <= bad_reg;
        end
    end

    assign m_hip_angle   = hip_out_reg;
    assign m_knee_angle  = knee_out_reg;
    assign m_unreachable = unr_out_reg;

    // ---------------- checks ----------------
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_hip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hip_angle <= ANGLE_W'(OUT_LIMIT)) &&
                    (m_hip_angle >= -ANGLE_W'(OUT_LIMIT)))
        else $error("hip angle outside saturation range");

    a_knee_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_knee_angle <= ANGLE_W'(OUT_LIMIT)) &&
                    (m_knee_angle >= -ANGLE_W'(OUT_LIMIT)))
        else $error("knee angle outside saturation range");

endmodule
